@@ src/l3f_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l3f_pkg
// types, register indexes and the kernel arithmetic shared by the filter
// ----------------------------------------------------------------------------
package l3f_pkg;

    localparam int DEF_MAX_WIDTH    = 4096;
    localparam int DEF_MAX_CHANNELS = 3;
    localparam int MAX_HEIGHT       = 4096;

    localparam logic [2:0] REG_WIDTH    = 3'd0;
    localparam logic [2:0] REG_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_CHANNELS = 3'd2;
    localparam logic [2:0] REG_BORDER   = 3'd3;
    localparam logic [2:0] REG_BVALUE   = 3'd4;
    localparam logic [2:0] REG_FORMAT   = 3'd5;

    localparam logic [1:0] MODE_CONST   = 2'd0;
    localparam logic [1:0] MODE_REPL    = 2'd1;
    localparam logic [1:0] MODE_REFLECT = 2'd2;

    localparam logic [1:0] FMT_U8  = 2'd0;
    localparam logic [1:0] FMT_U16 = 2'd1;
    localparam logic [1:0] FMT_S16 = 2'd2;

    localparam logic [12:0] RST_WIDTH    = 13'd640;
    localparam logic [12:0] RST_HEIGHT   = 13'd480;
    localparam logic [1:0]  RST_CHANNELS = 2'd1;
    localparam logic [1:0]  RST_BORDER   = MODE_REFLECT;
    localparam logic [15:0] RST_BVALUE   = 16'd0;
    localparam logic [1:0]  RST_FORMAT   = FMT_U8;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic        command;
        logic [15:0] pixel_value;
    } t_in;

    typedef struct packed {
        logic [15:0] filtered_value;
        logic        row_end;
        logic        frame_end;
    } t_out;

    function automatic logic signed [16:0] as_value(input logic [15:0] raw,
                                                    input logic [1:0] fmt);
        logic signed [16:0] v;
        if (fmt == FMT_U8) begin
            v = $signed({9'd0, raw[7:0]});
        end else if (fmt == FMT_U16) begin
            v = $signed({1'b0, raw});
        end else begin
            v = $signed({raw[15], raw});
        end
        return v;
    endfunction

    function automatic logic [15:0] laplace(input logic [15:0] lp, input logic [15:0] ln,
                                            input logic [15:0] rp, input logic [15:0] rn,
                                            input logic [15:0] c, input logic [1:0] fmt);
        logic signed [20:0] sum;
        logic signed [20:0] r;
        logic [15:0]        res;
        sum = 21'(as_value(lp, fmt)) + 21'(as_value(ln, fmt))
            + 21'(as_value(rp, fmt)) + 21'(as_value(rn, fmt));
        r = (sum <<< 1) - (21'(as_value(c, fmt)) <<< 3);
        if (fmt == FMT_U16) begin
            if (r < 0) begin
                res = 16'd0;
            end else if (r > 21'sd65535) begin
                res = 16'hFFFF;
            end else begin
                res = r[15:0];
            end
        end else if (fmt == FMT_U8) begin
            res = r[15:0];
        end else begin
            if (r < -21'sd32768) begin
                res = 16'h8000;
            end else if (r > 21'sd32767) begin
                res = 16'h7FFF;
            end else begin
                res = r[15:0];
            end
        end
        return res;
    endfunction

endpackage

@@ src/l3f_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l3f_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module l3f_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/laplacian_3x3_image_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laplacian_3x3_image_filter
// 3x3 laplacian over interleaved raster samples with two line-store rams
//
//  channel   signals                                 item
//  input     i_in_valid / o_in_stall / i_in_data     pixel sample or drain step
//  output    o_out_valid / i_out_stall / o_out_data  filtered sample
//  config    i_cfg_we / i_cfg_index / i_cfg_data     register write
//
//  one item per cycle while o_in_stall is low; results pass through stage 1 and the result queue
//  two line-store ram reads issue at accept, write-back in the cycle after
//  the last column of a row gives two results through a 4-entry pair queue
//  o_in_stall rises while more than two queue entries are held
//  reset is synchronous; line stores need no clearing
// ----------------------------------------------------------------------------
module laplacian_3x3_image_filter
    import l3f_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // configuration
    logic [12:0] r_width, r_height;
    logic [1:0]  r_chans, r_border, r_format;
    logic [15:0] r_bvalue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_chans  <= RST_CHANNELS;
            r_border <= RST_BORDER;
            r_bvalue <= RST_BVALUE;
            r_format <= RST_FORMAT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WIDTH:    r_width  <= i_cfg_data[12:0];
                REG_HEIGHT:   r_height <= i_cfg_data[12:0];
                REG_CHANNELS: r_chans  <= i_cfg_data[1:0];
                REG_BORDER:   r_border <= i_cfg_data[1:0];
                REG_BVALUE:   r_bvalue <= i_cfg_data;
                REG_FORMAT:   r_format <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic        cfg_hit;
    logic [15:0] w_last;
    logic [12:0] h_eff;
    logic [1:0]  n_eff, mode, fmt;

    assign cfg_hit = i_cfg_we && (i_cfg_index <= REG_FORMAT);

    always_comb begin
        logic [15:0] w16;
        w16 = {3'd0, r_width};
        if (w16 < 16'd2) begin
            w16 = 16'd2;
        end else if (w16 > 16'(MAX_WIDTH)) begin
            w16 = 16'(MAX_WIDTH);
        end
        w_last = w16 - 16'd1;
        h_eff  = (r_height < 13'd2) ? 13'd2 :
                 (r_height > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : r_height;
        n_eff  = (r_chans == 2'd0) ? 2'd1 :
                 (r_chans > 2'(MAX_CHANNELS)) ? 2'(MAX_CHANNELS) : r_chans;
        mode   = (r_border == 2'd3) ? MODE_REFLECT : r_border;
        fmt    = (r_format == 2'd3) ? FMT_S16 : r_format;
    end

    // position counters, advanced for each accepted pixel, or any accepted item in the drain row
    logic [AW-1:0] r_col;
    logic [XW-1:0] r_x;
    logic [CW-1:0] r_ch;
    logic [12:0]   r_row;
    logic          drain_row, accept, take, ch_last, x_last;

    assign drain_row = (r_row >= h_eff);
    assign accept    = i_in_valid && !o_in_stall;
    assign take      = accept && (drain_row || (i_in_data.command == CMD_PIXEL));
    assign ch_last   = ({{(32-CW){1'b0}}, r_ch} == 32'(n_eff) - 32'd1);
    assign x_last    = (16'(r_x) == w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_col <= '0;
            r_x   <= '0;
            r_ch  <= '0;
            r_row <= '0;
        end else if (take) begin
            if (ch_last) begin
                r_ch <= '0;
                if (x_last) begin
                    r_x   <= '0;
                    r_col <= '0;
                    r_row <= drain_row ? 13'd0 : r_row + 13'd1;
                end else begin
                    r_x   <= r_x + XW'(1);
                    r_col <= r_col + AW'(1);
                end
            end else begin
                r_ch  <= r_ch + CW'(1);
                r_col <= r_col + AW'(1);
            end
        end
    end

    // stage 1: ram data back, modify and write
    logic          r_s1_valid;
    logic [AW-1:0] r_s1_col;
    logic [CW-1:0] r_s1_ch;
    logic [15:0]   r_s1_vin;
    logic          r_s1_row0, r_s1_row1, r_s1_drain, r_s1_x0, r_s1_x1;
    logic          r_s1_xlast, r_s1_chlast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= take;
        end
        r_s1_col    <= r_col;
        r_s1_ch     <= r_ch;
        r_s1_vin    <= i_in_data.pixel_value;
        r_s1_row0   <= (r_row == 13'd0);
        r_s1_row1   <= (r_row == 13'd1);
        r_s1_drain  <= drain_row;
        r_s1_x0     <= (r_x == XW'(0));
        r_s1_x1     <= (r_x == XW'(1));
        r_s1_xlast  <= x_last;
        r_s1_chlast <= ch_last;
    end

    logic [15:0] up, mid;

    l3f_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (mid),
        .i_raddr (r_col),
        .o_rdata (up)
    );

    logic [15:0] p, n;

    l3f_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (n),
        .i_raddr (r_col),
        .o_rdata (mid)
    );

    // window: previous two columns per channel, [0..2] older, [3..5] newer
    logic [15:0] r_win [MAX_CHANNELS][6];
    logic [15:0] w0a, w0c, w1a, w1b, w1c, lp, ln, rp, rn;
    logic [15:0] res0, res1;

    always_comb begin
        n = r_s1_vin;
        if (r_s1_drain) begin
            n = (mode == MODE_CONST) ? r_bvalue : (mode == MODE_REPL) ? mid : up;
        end
        p = up;
        if (r_s1_row1) begin
            p = (mode == MODE_CONST) ? r_bvalue : (mode == MODE_REPL) ? mid : n;
        end
        w0a = r_win[r_s1_ch][0];
        w0c = r_win[r_s1_ch][2];
        w1a = r_win[r_s1_ch][3];
        w1b = r_win[r_s1_ch][4];
        w1c = r_win[r_s1_ch][5];
        if (r_s1_x1) begin
            unique case (mode)
                MODE_CONST: begin lp = r_bvalue; ln = r_bvalue; end
                MODE_REPL:  begin lp = w1a;      ln = w1c;      end
                default:    begin lp = p;        ln = n;        end
            endcase
        end else begin
            lp = w0a;
            ln = w0c;
        end
        unique case (mode)
            MODE_CONST: begin rp = r_bvalue; rn = r_bvalue; end
            MODE_REPL:  begin rp = p;        rn = n;        end
            default:    begin rp = w1a;      rn = w1c;      end
        endcase
        res0 = laplace(lp, ln, p, n, w1b, fmt);
        res1 = laplace(w1a, w1c, rp, rn, mid, fmt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                for (int j = 0; j < 6; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (r_s1_valid && !r_s1_row0) begin
            r_win[r_s1_ch][0] <= w1a;
            r_win[r_s1_ch][1] <= w1b;
            r_win[r_s1_ch][2] <= w1c;
            r_win[r_s1_ch][3] <= p;
            r_win[r_s1_ch][4] <= mid;
            r_win[r_s1_ch][5] <= n;
        end
    end

    // result queue: each entry holds one or two items of one input item
    logic [15:0] r_q_first  [4];
    t_out        r_q_second [4];
    logic        r_q_two    [4];
    logic [1:0]  r_head, r_tail;
    logic [2:0]  r_cnt;
    logic        r_sub;
    logic        push, pop_item, pop_entry;

    assign push      = r_s1_valid && !r_s1_row0 && !r_s1_x0;
    assign o_in_stall = (r_cnt > 3'd2);
    assign o_out_valid = (r_cnt != 3'd0);
    assign pop_item  = o_out_valid && !i_out_stall;
    assign pop_entry = pop_item && (r_sub || !r_q_two[r_head]);

    always_comb begin
        if (r_sub) begin
            o_out_data = r_q_second[r_head];
        end else begin
            o_out_data.filtered_value = r_q_first[r_head];
            o_out_data.row_end        = 1'b0;
            o_out_data.frame_end      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_first[r_tail]                 <= res0;
            r_q_two[r_tail]                   <= r_s1_xlast;
            r_q_second[r_tail].filtered_value <= res1;
            r_q_second[r_tail].row_end        <= r_s1_chlast;
            r_q_second[r_tail].frame_end      <= r_s1_chlast && r_s1_drain;
        end
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
            r_sub  <= 1'b0;
        end else begin
            if (push) begin
                r_tail <= r_tail + 2'd1;
            end
            if (pop_entry) begin
                r_head <= r_head + 2'd1;
                r_sub  <= 1'b0;
            end else if (pop_item) begin
                r_sub  <= 1'b1;
            end
            r_cnt <= r_cnt + 3'(push) - 3'(pop_entry);
        end
    end

    // checks
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 3'd4)
        else $error("result queue overflow");
    a_q_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_cnt < 3'd4))
        else $error("no room for item in flight");
    a_sub_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (o_out_valid && r_q_two[r_head]))
        else $error("second result selected on single entry");
    a_addr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_s1_valid) |-> (r_col != r_s1_col))
        else $error("line store read and write collide");
endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for laplacian_3x3_image_filter: a directed table of
// frames and drains, then random frames over several settings; every result
// is compared with a filter model kept in the bench, with random idling on
// both channels and a long output hold-off
// ----------------------------------------------------------------------------
module tb;
    import l3f_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    laplacian_3x3_image_filter DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // filter model state
    logic [15:0] upper_row [DEF_MAX_WIDTH*DEF_MAX_CHANNELS];
    logic [15:0] middle_row[DEF_MAX_WIDTH*DEF_MAX_CHANNELS];
    logic [15:0] win[18];
    int unsigned col_pos, row_pos;
    logic [15:0] cfg_regs[6];

    t_out pending_results[$];
    int   pushed = 0;
    int   mismatches = 0;
    bit   quiet_mode = 0;
    int   hold_cycles = 0;

    function automatic int signed sample_value(logic [15:0] raw, logic [1:0] fmt);
        if (fmt == FMT_U8) return int'(raw[7:0]);
        if (fmt == FMT_U16) return int'(raw);
        return int'($signed(raw));
    endfunction

    function automatic logic [15:0] kernel(logic [15:0] lp, logic [15:0] ln,
                                           logic [15:0] rp, logic [15:0] rn,
                                           logic [15:0] c, logic [1:0] fmt);
        int signed r;
        r = 2 * (sample_value(lp, fmt) + sample_value(ln, fmt) + sample_value(rp, fmt)
            + sample_value(rn, fmt)) - 8 * sample_value(c, fmt);
        if (fmt == FMT_U16) begin
            if (r < 0) r = 0;
            if (r > 65535) r = 65535;
        end else if (fmt != FMT_U8) begin
            if (r < -32768) r = -32768;
            if (r > 32767) r = 32767;
        end
        return r[15:0];
    endfunction

    task automatic model_config(logic [2:0] idx, logic [15:0] val);
        logic [15:0] m;
        case (idx)
            REG_WIDTH, REG_HEIGHT: m = 16'h1FFF;
            REG_BVALUE: m = 16'hFFFF;
            default: m = 16'h3;
        endcase
        if (idx < 6) cfg_regs[idx] = val & m;
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic predict_filter(t_in it);
        int unsigned w, h, nch, total, s, ch, x, w0, w1;
        logic [1:0] mode, fmt;
        logic [15:0] bv, up, mid, p, c, n, lp, ln, rp, rn;
        bit drain_row, last;
        t_out r;
        w = 32'(cfg_regs[REG_WIDTH]); h = 32'(cfg_regs[REG_HEIGHT]);
        nch = 32'(cfg_regs[REG_CHANNELS]);
        mode = cfg_regs[REG_BORDER][1:0]; fmt = cfg_regs[REG_FORMAT][1:0];
        bv = cfg_regs[REG_BVALUE];
        if (w < 2) w = 2;
        if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
        if (h < 2) h = 2;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        if (nch < 1) nch = 1;
        if (nch > DEF_MAX_CHANNELS) nch = DEF_MAX_CHANNELS;
        if (mode > MODE_REFLECT) mode = MODE_REFLECT;
        if (fmt > FMT_S16) fmt = FMT_S16;
        drain_row = row_pos >= h;
        if (!drain_row && it.command == CMD_DRAIN) return;
        total = w * nch;
        if (col_pos >= total) col_pos = 0;
        s = col_pos; ch = s % nch; x = s / nch;
        up = upper_row[s]; mid = middle_row[s];
        if (row_pos == 0) begin
            upper_row[s] = mid;
            middle_row[s] = it.pixel_value;
            col_pos++;
            if (col_pos >= total) begin
                col_pos = 0;
                row_pos = 1;
            end
            return;
        end
        p = up; c = mid; n = it.pixel_value;
        if (drain_row) n = (mode == MODE_CONST) ? bv : (mode == MODE_REPL) ? mid : up;
        if (row_pos == 1) p = (mode == MODE_CONST) ? bv : (mode == MODE_REPL) ? mid : n;
        upper_row[s] = mid;
        middle_row[s] = n;
        w0 = ch * 6; w1 = w0 + 3;
        if (x >= 1) begin
            if (x == 1) begin
                if (mode == MODE_CONST) begin lp = bv; ln = bv; end
                else if (mode == MODE_REPL) begin lp = win[w1]; ln = win[w1+2]; end
                else begin lp = p; ln = n; end
            end else begin
                lp = win[w0]; ln = win[w0+2];
            end
            r.filtered_value = kernel(lp, ln, p, n, win[w1+1], fmt);
            r.row_end = 1'b0; r.frame_end = 1'b0;
            pending_results.push_back(r);
            pushed++;
        end
        if (x == w - 1) begin
            if (mode == MODE_CONST) begin rp = bv; rn = bv; end
            else if (mode == MODE_REPL) begin rp = p; rn = n; end
            else begin rp = win[w1]; rn = win[w1+2]; end
            last = (ch == nch - 1);
            r.filtered_value = kernel(win[w1], win[w1+2], rp, rn, c, fmt);
            r.row_end = last; r.frame_end = last && drain_row;
            pending_results.push_back(r);
            pushed++;
        end
        win[w0] = win[w1]; win[w0+1] = win[w1+1]; win[w0+2] = win[w1+2];
        win[w1] = p; win[w1+1] = c; win[w1+2] = n;
        col_pos++;
        if (col_pos >= total) begin
            col_pos = 0;
            row_pos = drain_row ? 0 : row_pos + 1;
        end
    endtask

    // output side: random stall and checking
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_out_data);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %h/%b/%b got %h/%b/%b",
                                 want.filtered_value, want.row_end, want.frame_end,
                                 o_out_data.filtered_value, o_out_data.row_end,
                                 o_out_data.frame_end);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet_mode && ($urandom_range(99) < 30);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        model_config(idx, val);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // leaves valid high after the accepting edge; at the following falling
    // edge wait_idle drops it, and the next call drops it or sends a new item
    task automatic send_item(logic cmd, logic [15:0] val);
        t_in it;
        while (!quiet_mode && $urandom_range(99) < 30) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        it.command = cmd; it.pixel_value = val;
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_filter(it);
        @(negedge i_clk);
    endtask

    task automatic setup(int w, int h, int nch, logic [1:0] mode, logic [15:0] bv,
                         logic [1:0] fmt);
        wait_idle();
        write_reg(REG_WIDTH, w[15:0]);
        write_reg(REG_HEIGHT, h[15:0]);
        write_reg(REG_CHANNELS, nch[15:0]);
        write_reg(REG_BORDER, {14'd0, mode});
        write_reg(REG_BVALUE, bv);
        write_reg(REG_FORMAT, {14'd0, fmt});
    endtask

    function automatic logic [15:0] rand_pixel(logic [1:0] fmt);
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic run_frame(int w, int h, int nch, logic [1:0] fmt);
        for (int i = 0; i < w * nch * (h + 1); i++) begin
            if (i < w * nch * h && $urandom_range(19) == 0)
                send_item(CMD_DRAIN, 16'($urandom()));
            send_item((i >= w * nch * h) ? CMD_DRAIN : CMD_PIXEL, rand_pixel(fmt));
        end
    endtask

    typedef struct {
        logic        cmd;
        logic [15:0] val;
        bit          checked;
        t_out        want;
    } t_row;

    // 2x2 frame, constant border zero; flat input gives zero everywhere
    // early drain ignored, pixel in drain row acts as a drain step
    t_row directed_rows[] = '{
        '{CMD_DRAIN, 16'h00FF, 0, '0},
        '{CMD_PIXEL, 16'h0000, 0, '0},
        '{CMD_PIXEL, 16'h0000, 0, '0},
        '{CMD_PIXEL, 16'h0000, 0, '0},
        '{CMD_PIXEL, 16'h0000, 1, '{16'h0000, 1'b1, 1'b0}},
        '{CMD_PIXEL, 16'hFFFF, 0, '0},
        '{CMD_DRAIN, 16'h0000, 1, '{16'h0000, 1'b1, 1'b1}},
        '{CMD_DRAIN, 16'h0000, 0, '0}
    };

    initial begin
        int w, h, nch, seg, qlen;
        for (int k = 0; k < 18; k++) win[k] = '0;
        cfg_regs[REG_WIDTH] = RST_WIDTH; cfg_regs[REG_HEIGHT] = RST_HEIGHT;
        cfg_regs[REG_CHANNELS] = RST_CHANNELS; cfg_regs[REG_BORDER] = RST_BORDER;
        cfg_regs[REG_BVALUE] = RST_BVALUE; cfg_regs[REG_FORMAT] = RST_FORMAT;
        col_pos = 0; row_pos = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: all channel counts, modes and formats on tiny frames
        for (int fmtv = 0; fmtv < 3; fmtv++) begin
            setup(2, 2, 1, MODE_CONST, 16'h0000, fmtv[1:0]);
            foreach (directed_rows[k]) begin
                qlen = pushed;
                send_item(directed_rows[k].cmd, directed_rows[k].val);
                if (directed_rows[k].checked) begin
                    if ((pushed - qlen != 2) ||
                        (pending_results[$] !== directed_rows[k].want)) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("directed row %0d: expected %h got %h", k,
                                     directed_rows[k].want, pending_results[$]);
                    end
                end
            end
        end
        setup(3, 2, 3, MODE_REPL, 16'hFFFF, FMT_S16);
        run_frame(3, 2, 3, FMT_S16);
        setup(2, 3, 2, 2'd3, 16'h8000, 2'd3);
        run_frame(2, 3, 2, FMT_S16);
        // out-of-range registers are clamped
        setup(0, 1, 0, MODE_CONST, 16'hFFFF, FMT_U16);
        run_frame(2, 2, 1, FMT_U16);

        // random frames over random settings
        for (seg = 0; seg < 10; seg++) begin
            quiet_mode = (seg == 5);
            w = (seg == 9) ? 16 : $urandom_range(2, 6);
            h = $urandom_range(2, 4);
            nch = $urandom_range(1, 3);
            setup(w, h, nch, 2'($urandom_range(2)), rand_pixel(FMT_U16),
                  2'($urandom_range(2)));
            if (seg == 3) hold_cycles = 200;
            run_frame(w, h, nch, cfg_regs[REG_FORMAT][1:0]);
            if (seg == 7) wait_idle();
        end
        quiet_mode = 0;
        // 13-bit extremes once, then abandon the frame
        setup(8191, 8191, 3, MODE_REFLECT, 16'h0000, FMT_U8);
        for (int k = 0; k < 30; k++) send_item(CMD_PIXEL, 16'($urandom()));
        wait_idle();

        if (mismatches == 0) begin
            $display("laplacian_3x3_image_filter: match");
        end else begin
            $display("laplacian_3x3_image_filter: mismatch");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("laplacian_3x3_image_filter: mismatch");
        $finish;
    end
endmodule
